>>> hdl/mfet_pkg.sv
// Shared types, constants and step codes for the magnet fractal escape-time block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package mfet_pkg;

	// Number formats
	localparam int FRAC  = 28;               // fraction bits of every value
	localparam int WW    = 44;               // wide intermediate, signed Q16.28
	localparam int QW    = 32;               // c and z, signed Q4.28
	localparam int XW    = 48;               // headroom for sums before saturation
	localparam int PW    = 10;               // pixel coordinate width
	localparam int IW    = 7;                // iteration count field width
	localparam int ZW    = 31;               // zoom register width

	// Multiplier: full product of two magnitudes, one chunk of b per cycle
	localparam int PRW    = 2 * WW;
	localparam int MCH    = 11;
	localparam int MSTEPS = WW / MCH;

	// Divider: long division of a (WW+FRAC)-bit dividend, one quotient bit per cycle
	localparam int DNW   = WW + FRAC;
	localparam int QBW   = WW - 1;

	localparam logic signed [WW-1:0] WIDE_MAX = {1'b0, {(WW-1){1'b1}}};
	localparam logic signed [WW-1:0] WIDE_MIN = {1'b1, {(WW-1){1'b0}}};
	localparam logic signed [QW-1:0] Q_MAX    = {1'b0, {(QW-1){1'b1}}};
	localparam logic signed [QW-1:0] Q_MIN    = {1'b1, {(QW-1){1'b0}}};
	localparam logic signed [XW-1:0] ONE_X    = XW'(64'sd1 <<< FRAC);

	// Configuration port
	localparam int CFG_IW = 2;
	localparam int CFG_DW = 32;
	localparam logic [CFG_IW-1:0] REG_ZOOM      = 2'd0;
	localparam logic [CFG_IW-1:0] REG_OFFSET_RE = 2'd1;
	localparam logic [CFG_IW-1:0] REG_OFFSET_IM = 2'd2;

	localparam logic [ZW-1:0]        ZOOM_RST   = 31'h4000_0000;
	localparam logic signed [QW-1:0] OFFSET_RST = '0;

	// Parameter defaults
	localparam int DEF_IMG_WIDTH  = 1024;
	localparam int DEF_IMG_HEIGHT = 1024;
	localparam int DEF_MAX_ITER   = 100;

	// Datapath steps, issued in order by the controller
	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] STEP_MAPX_MUL = 5'd0;
	localparam logic [STEP_W-1:0] STEP_MAPX_DIV = 5'd1;
	localparam logic [STEP_W-1:0] STEP_MAPY_MUL = 5'd2;
	localparam logic [STEP_W-1:0] STEP_MAPY_DIV = 5'd3;
	localparam logic [STEP_W-1:0] STEP_ZZ0      = 5'd4;
	localparam logic [STEP_W-1:0] STEP_ZZ1      = 5'd5;
	localparam logic [STEP_W-1:0] STEP_CHK      = 5'd6;
	localparam logic [STEP_W-1:0] STEP_Z01      = 5'd7;
	localparam logic [STEP_W-1:0] STEP_DD0      = 5'd8;
	localparam logic [STEP_W-1:0] STEP_DD1      = 5'd9;
	localparam logic [STEP_W-1:0] STEP_ND00     = 5'd10;
	localparam logic [STEP_W-1:0] STEP_ND11     = 5'd11;
	localparam logic [STEP_W-1:0] STEP_ND10     = 5'd12;
	localparam logic [STEP_W-1:0] STEP_ND01     = 5'd13;
	localparam logic [STEP_W-1:0] STEP_DIVA     = 5'd14;
	localparam logic [STEP_W-1:0] STEP_DIVB     = 5'd15;
	localparam logic [STEP_W-1:0] STEP_QQ0      = 5'd16;
	localparam logic [STEP_W-1:0] STEP_QQ1      = 5'd17;
	localparam logic [STEP_W-1:0] STEP_QQ01     = 5'd18;

	typedef struct packed {
		logic              load;   // input transfer: capture pixel, clear z
		logic              start;  // launch the step below
		logic [STEP_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic done;   // step finished, results written
		logic stop;   // last check found escape or zero denominator
	} stat_t;

endpackage

>>> hdl/mfet_if.sv
// Valid/ready channel interfaces for pixel input and escape-time results.
// Depends on mfet_pkg for field widths.
`timescale 1ns / 1ps

interface mfet_pix_if;
	import mfet_pkg::*;
	logic          valid;
	logic          ready;
	logic [PW-1:0] pixel_x;
	logic [PW-1:0] pixel_y;
	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface mfet_res_if;
	import mfet_pkg::*;
	logic          valid;
	logic          ready;
	logic [PW-1:0] out_x;
	logic [PW-1:0] out_y;
	logic [IW-1:0] iterations;
	modport source (output valid, output out_x, output out_y, output iterations, input ready);
	modport sink   (input valid, input out_x, input out_y, input iterations, output ready);
endinterface

>>> hdl/mfet_mul.sv
// Multi-cycle unsigned multiplier: full product of two magnitudes, one chunk per cycle.
// Depends on mfet_pkg.
`timescale 1ns / 1ps

module mfet_mul (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [mfet_pkg::WW-1:0]  a,
	input  logic [mfet_pkg::WW-1:0]  b,
	output logic                     done,
	output logic [mfet_pkg::PRW-1:0] prod
);
	import mfet_pkg::*;

	localparam int CW = $clog2(MSTEPS);

	logic [WW-1:0]     a_q, b_q;
	logic [PRW-1:0]    acc_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q, done_q;
	logic [WW+MCH-1:0] pp;

	// Partial product of a with the top chunk of b
	assign pp = {{MCH{1'b0}}, a_q} * {{WW{1'b0}}, b_q[WW-1 -: MCH]};

	// Shift in one chunk per cycle, most significant first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(MSTEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(MSTEPS - 1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= (acc_q << MCH) + PRW'(pp);
			b_q   <= b_q << MCH;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

>>> hdl/mfet_div.sv
// Restoring divider, one quotient bit per cycle; quotient must fit QBW bits.
// Depends on mfet_pkg.
`timescale 1ns / 1ps

module mfet_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [mfet_pkg::DNW-1:0] num,
	input  logic [mfet_pkg::WW-1:0]  den,
	output logic                     done,
	output logic [mfet_pkg::QBW-1:0] quo
);
	import mfet_pkg::*;

	localparam int CW = $clog2(QBW);

	logic [WW-1:0]  r_q, den_q;
	logic [QBW-1:0] n_q, q_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q, done_q;
	logic [WW:0]    t, diff;
	logic           ge;

	// Trial subtract of the divisor from the shifted remainder
	assign t    = {r_q, n_q[QBW-1]};
	assign diff = t - {1'b0, den_q};
	assign ge   = t >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(QBW - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(QBW - 1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= {{(WW - (DNW - QBW)){1'b0}}, num[DNW-1:QBW]};
			n_q   <= num[QBW-1:0];
			den_q <= den;
			q_q   <= '0;
		end else if (busy_q) begin
			r_q <= ge ? diff[WW-1:0] : t[WW-1:0];
			n_q <= n_q << 1;
			q_q <= {q_q[QBW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = q_q;

endmodule

>>> hdl/mfet_dp.sv
// Datapath: value registers, operand selection, saturation, shared multiplier and divider.
// Depends on mfet_pkg, mfet_mul and mfet_div.
`timescale 1ns / 1ps

module mfet_dp #(
	parameter int IMG_WIDTH  = mfet_pkg::DEF_IMG_WIDTH,
	parameter int IMG_HEIGHT = mfet_pkg::DEF_IMG_HEIGHT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mfet_pkg::cmd_t                 cmd,
	input  logic [mfet_pkg::PW-1:0]        pixel_x,
	input  logic [mfet_pkg::PW-1:0]        pixel_y,
	input  logic [mfet_pkg::ZW-1:0]        zoom,
	input  logic signed [mfet_pkg::QW-1:0] offset_re,
	input  logic signed [mfet_pkg::QW-1:0] offset_im,
	output mfet_pkg::stat_t                status,
	output logic [mfet_pkg::PW-1:0]        px,
	output logic [mfet_pkg::PW-1:0]        py
);
	import mfet_pkg::*;

	typedef logic signed [WW-1:0] wide_t;
	typedef logic signed [XW-1:0] ext_t;
	typedef logic signed [QW-1:0] q_t;

	function automatic ext_t x48(input wide_t v);
		return ext_t'(v);
	endfunction

	function automatic wide_t sat_wide(input ext_t v);
		if (v > x48(WIDE_MAX)) return WIDE_MAX;
		if (v < x48(WIDE_MIN)) return WIDE_MIN;
		return wide_t'(v);
	endfunction

	function automatic q_t sat_q(input ext_t v);
		if (v > ext_t'(Q_MAX)) return Q_MAX;
		if (v < ext_t'(Q_MIN)) return Q_MIN;
		return q_t'(v);
	endfunction

	function automatic logic [WW-1:0] mag(input wide_t v);
		return v[WW-1] ? -v : v;
	endfunction

	// Truncated Q.28 product from the magnitude product, signed and saturated
	function automatic wide_t fmul_fin(input logic [PRW-1:0] p, input logic neg);
		logic [PRW-FRAC-1:0] m;
		logic [PRW-FRAC-1:0] lim;
		m   = p[PRW-1:FRAC];
		lim = (PRW-FRAC)'(1) << (WW - 1);
		if (neg) return (m > lim) ? WIDE_MIN : -wide_t'(m[WW-1:0]);
		return (m >= lim) ? WIDE_MAX : wide_t'(m[WW-1:0]);
	endfunction

	// Value registers
	logic [PW-1:0]  px_q, py_q;
	q_t             c0_q, c1_q, z0_q, z1_q;
	wide_t          d0_q, d1_q, n0_q, n1_q, gd_q, a_q, b_q, q0_q, q1_q, p0_q, p1_q;
	logic [WW-1:0]  mp_q;
	logic           neg_q;
	logic [STEP_W-1:0] step_q;
	logic           imm_q, stop_q;

	// Unit hookup
	wide_t          ma, mb;
	logic           is_mul, is_fdiv, is_map_div;
	logic           mul_go, div_go, div_sat, imm_go;
	logic           mul_done, div_done;
	logic [PRW-1:0] prod;
	logic [DNW-1:0] dnum;
	logic [WW-1:0]  dden;
	logic [QBW-1:0] quo;
	wide_t          dn, dx, dy, satv, r, qs, sv;
	logic [WW-1:0]  dn_mag;

	// Check step values
	wide_t d0n, d1n, n0n;
	logic  esc;

	assign dx = wide_t'({{(WW-PW){1'b0}}, px_q}) - wide_t'(IMG_WIDTH / 2);
	assign dy = wide_t'({{(WW-PW){1'b0}}, py_q}) - wide_t'(IMG_HEIGHT / 2);

	// Select multiplier operands for the step being launched
	always_comb begin
		ma     = '0;
		mb     = '0;
		is_mul = 1'b1;
		case (cmd.step)
			STEP_MAPX_MUL: begin ma = dx; mb = wide_t'({{(WW-ZW){1'b0}}, zoom}); end
			STEP_MAPY_MUL: begin ma = dy; mb = wide_t'({{(WW-ZW){1'b0}}, zoom}); end
			STEP_ZZ0:  begin ma = wide_t'(z0_q); mb = wide_t'(z0_q); end
			STEP_ZZ1:  begin ma = wide_t'(z1_q); mb = wide_t'(z1_q); end
			STEP_Z01:  begin ma = wide_t'(z0_q); mb = wide_t'(z1_q); end
			STEP_DD0:  begin ma = d0_q; mb = d0_q; end
			STEP_DD1:  begin ma = d1_q; mb = d1_q; end
			STEP_ND00: begin ma = n0_q; mb = d0_q; end
			STEP_ND11: begin ma = n1_q; mb = d1_q; end
			STEP_ND10: begin ma = n1_q; mb = d0_q; end
			STEP_ND01: begin ma = n0_q; mb = d1_q; end
			STEP_QQ0:  begin ma = q0_q; mb = q0_q; end
			STEP_QQ1:  begin ma = q1_q; mb = q1_q; end
			STEP_QQ01: begin ma = q0_q; mb = q1_q; end
			default:   is_mul = 1'b0;
		endcase
	end

	// Select divider operands: pixel mapping or complex quotient
	always_comb begin
		is_fdiv    = 1'b0;
		is_map_div = 1'b0;
		dn         = '0;
		dnum       = {{FRAC{1'b0}}, mp_q};
		dden       = WW'(IMG_WIDTH);
		case (cmd.step)
			STEP_MAPX_DIV: is_map_div = 1'b1;
			STEP_MAPY_DIV: begin is_map_div = 1'b1; dden = WW'(IMG_HEIGHT); end
			STEP_DIVA:     begin is_fdiv = 1'b1; dn = a_q; end
			STEP_DIVB:     begin is_fdiv = 1'b1; dn = b_q; end
			default:       ;
		endcase
		if (is_fdiv) begin
			dnum = {mag(dn), {FRAC{1'b0}}};
			dden = gd_q;
		end
	end

	assign dn_mag  = mag(dn);
	// Zero modulus or a quotient too large for the wide range
	assign div_sat = is_fdiv && ((gd_q == '0) ||
		({{(QW-FRAC-1+WW-QW+4){1'b0}}, dn_mag} >= {gd_q, {(WW-FRAC-1){1'b0}}}));
	assign satv    = (dn > 0) ? WIDE_MAX : ((dn < 0) ? WIDE_MIN : '0);

	assign mul_go = cmd.start && is_mul;
	assign div_go = cmd.start && (is_map_div || (is_fdiv && !div_sat));
	assign imm_go = cmd.start && ((cmd.step == STEP_CHK) || div_sat);

	mfet_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_go),
		.a      (mag(ma)),
		.b      (mag(mb)),
		.done   (mul_done),
		.prod   (prod)
	);

	mfet_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go),
		.num    (dnum),
		.den    (dden),
		.done   (div_done),
		.quo    (quo)
	);

	assign r  = fmul_fin(prod, neg_q);
	assign qs = wide_t'({1'b0, quo});
	assign sv = neg_q ? -qs : qs;

	// Escape test, denominator and real numerator
	assign d0n = (wide_t'(z0_q) <<< 1) + wide_t'(c0_q) - wide_t'(ONE_X <<< 1);
	assign d1n = (wide_t'(z1_q) <<< 1) + wide_t'(c1_q);
	assign n0n = sat_wide(x48(p0_q) - x48(p1_q) + ext_t'(c0_q) - ONE_X);
	assign esc = ((x48(p0_q) + x48(p1_q)) >= (ONE_X <<< 2)) || ((d0n == '0) && (d1n == '0));

	// Control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			imm_q  <= 1'b0;
			stop_q <= 1'b0;
		end else begin
			imm_q <= imm_go;
			if (cmd.start && cmd.step == STEP_CHK) stop_q <= esc;
		end
	end

	// Value registers: load, launch and write back
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q <= pixel_x;
			py_q <= pixel_y;
			z0_q <= '0;
			z1_q <= '0;
		end
		if (cmd.start) begin
			step_q <= cmd.step;
			if (is_mul) neg_q <= ma[WW-1] ^ mb[WW-1];
			if (is_fdiv) neg_q <= dn[WW-1];
			if (cmd.step == STEP_CHK) begin
				d0_q <= d0n;
				d1_q <= d1n;
				n0_q <= n0n;
			end
			if (div_sat && cmd.step == STEP_DIVA) q0_q <= satv;
			if (div_sat && cmd.step == STEP_DIVB) q1_q <= satv;
		end
		if (mul_done) begin
			case (step_q)
				STEP_MAPX_MUL, STEP_MAPY_MUL: mp_q <= prod[WW-1:0];
				STEP_ZZ0, STEP_DD0, STEP_ND00, STEP_ND10, STEP_QQ0: p0_q <= r;
				STEP_ZZ1:  p1_q <= r;
				STEP_Z01:  n1_q <= sat_wide((x48(r) <<< 1) + ext_t'(c1_q));
				STEP_DD1:  gd_q <= sat_wide(x48(p0_q) + x48(r));
				STEP_ND11: a_q  <= sat_wide(x48(p0_q) + x48(r));
				STEP_ND01: b_q  <= sat_wide(x48(p0_q) - x48(r));
				STEP_QQ1:  z0_q <= sat_q(x48(p0_q) - x48(r));
				STEP_QQ01: z1_q <= sat_q(x48(r) <<< 1);
				default:   ;
			endcase
		end
		if (div_done) begin
			case (step_q)
				STEP_MAPX_DIV: c0_q <= sat_q(x48(sv) + ext_t'(offset_re));
				STEP_MAPY_DIV: c1_q <= sat_q(x48(sv) + ext_t'(offset_im));
				STEP_DIVA:     q0_q <= sv;
				STEP_DIVB:     q1_q <= sv;
				default:       ;
			endcase
		end
	end

	assign status.done = imm_q | mul_done | div_done;
	assign status.stop = stop_q;
	assign px = px_q;
	assign py = py_q;

endmodule

>>> hdl/mfet_ctrl.sv
// Controller: sequences datapath steps per pixel and counts iterations.
// Depends on mfet_pkg.
`timescale 1ns / 1ps

module mfet_ctrl #(
	parameter int MAX_ITER = mfet_pkg::DEF_MAX_ITER
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    out_free,
	output logic                    emit,
	output logic [mfet_pkg::IW-1:0] iter,
	output mfet_pkg::cmd_t          cmd,
	input  mfet_pkg::stat_t         status
);
	import mfet_pkg::*;

	localparam int CW = $clog2(MAX_ITER + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;
	localparam logic [1:0] ST_OUT   = 2'd3;

	logic [1:0]        state_q;
	logic [STEP_W-1:0] step_q;
	logic [CW-1:0]     cnt_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign cmd.load  = in_valid && in_ready;
	assign cmd.start = (state_q == ST_ISSUE);
	assign cmd.step  = step_q;
	assign emit      = (state_q == ST_OUT) && out_free;
	assign iter      = IW'(cnt_q);

	// Advance through the step list; loop back after each full iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= STEP_MAPX_MUL;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						step_q  <= STEP_MAPX_MUL;
						cnt_q   <= '0;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (status.done) begin
						if (step_q == STEP_CHK && status.stop) begin
							state_q <= ST_OUT;
						end else if (step_q == STEP_QQ01) begin
							cnt_q <= cnt_q + 1'b1;
							if (cnt_q == CW'(MAX_ITER - 1)) begin
								state_q <= ST_OUT;
							end else begin
								step_q  <= STEP_ZZ0;
								state_q <= ST_ISSUE;
							end
						end else begin
							step_q  <= step_q + 1'b1;
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_OUT: if (emit) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_ITER))
		else $error("iteration count past limit");
	a_issue_wait: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ISSUE |=> state_q == ST_WAIT)
		else $error("launch not followed by wait");
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		status.done |-> state_q == ST_WAIT)
		else $error("step done outside wait");
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> in_ready)
		else $error("not idle after result");

endmodule

>>> hdl/magnet_fractal_escape_time_top.sv
// Magnet type I escape-time unit: one pixel in, one iteration count out.
// A pixel runs until its point escapes, hits a zero denominator or reaches MAX_ITER iterations.
// Each iteration issues twelve products on one multiplier (44x11 bits per cycle) and two
// quotients on one divider (one bit per cycle; a saturating quotient skips the divider).
// The pixel mapping costs one product and one quotient per axis. Pixels are handled
// one at a time; a finished result waits in an output register while the next pixel runs.
// Depends on mfet_pkg, mfet_if, mfet_ctrl and mfet_dp.
`timescale 1ns / 1ps

module magnet_fractal_escape_time_top #(
	parameter int IMG_WIDTH  = mfet_pkg::DEF_IMG_WIDTH,
	parameter int IMG_HEIGHT = mfet_pkg::DEF_IMG_HEIGHT,
	parameter int MAX_ITER   = mfet_pkg::DEF_MAX_ITER
) (
	input  logic                        clk,
	input  logic                        arst_n,
	mfet_pix_if.sink                    pix,
	mfet_res_if.source                  res,
	input  logic                        cfg_we,
	input  logic [mfet_pkg::CFG_IW-1:0] cfg_index,
	input  logic [mfet_pkg::CFG_DW-1:0] cfg_data
);
	import mfet_pkg::*;

	logic [ZW-1:0]        zoom_q;
	logic signed [QW-1:0] off_re_q, off_im_q;
	cmd_t                 cmd;
	stat_t                status;
	logic                 emit, out_free;
	logic [IW-1:0]        iter;
	logic [PW-1:0]        px, py;
	logic                 res_valid_q;
	logic [PW-1:0]        res_x_q, res_y_q;
	logic [IW-1:0]        res_it_q;

	// Configuration registers; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zoom_q   <= ZOOM_RST;
			off_re_q <= OFFSET_RST;
			off_im_q <= OFFSET_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ZOOM:      zoom_q   <= cfg_data[ZW-1:0];
				REG_OFFSET_RE: off_re_q <= cfg_data[QW-1:0];
				REG_OFFSET_IM: off_im_q <= cfg_data[QW-1:0];
				default:       ;
			endcase
		end
	end

	mfet_ctrl #(.MAX_ITER(MAX_ITER)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix.valid),
		.in_ready (pix.ready),
		.out_free (out_free),
		.emit     (emit),
		.iter     (iter),
		.cmd      (cmd),
		.status   (status)
	);

	mfet_dp #(.IMG_WIDTH(IMG_WIDTH), .IMG_HEIGHT(IMG_HEIGHT)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.pixel_x   (pix.pixel_x),
		.pixel_y   (pix.pixel_y),
		.zoom      (zoom_q),
		.offset_re (off_re_q),
		.offset_im (off_im_q),
		.status    (status),
		.px        (px),
		.py        (py)
	);

	// Output register: hold the result until its transfer
	assign out_free = !res_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_x_q  <= px;
			res_y_q  <= py;
			res_it_q <= iter;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.out_x      = res_x_q;
	assign res.out_y      = res_y_q;
	assign res.iterations = res_it_q;

endmodule
